FILE: design/lorenz_pkg.sv
// ----------------------------------------------------------------------------
// lorenz_pkg
// Shared types, constants and the sequencer microprogram for the Lorenz
// forward-Euler step unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lorenz_pkg;

  // Word format defaults (Q8.24)
  localparam int unsigned WORD_BITS_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF = 24;

  // Multiplier operand chunk width
  localparam int unsigned MUL_CHUNK = 32;

  // Register and port widths
  localparam int unsigned COEF_BITS     = 31;
  localparam int unsigned STEP_BITS     = 25;
  localparam int unsigned START_BITS    = 32;
  localparam int unsigned CFG_DATA_BITS = 32;
  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned OUT_BITS      = 32;

  // Register reset values
  localparam logic [COEF_BITS-1:0]  SIGMA_RST   = 31'd167772160;
  localparam logic [COEF_BITS-1:0]  RHO_RST     = 31'd469762048;
  localparam logic [COEF_BITS-1:0]  BETA_RST    = 31'd44739243;
  localparam logic [STEP_BITS-1:0]  STEP_RST    = 25'd16777;
  localparam logic [START_BITS-1:0] START_X_RST = 32'd16777;
  localparam logic [START_BITS-1:0] START_Y_RST = 32'd0;
  localparam logic [START_BITS-1:0] START_Z_RST = 32'd0;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_SIGMA   = 3'd0,
    CFG_RHO     = 3'd1,
    CFG_BETA    = 3'd2,
    CFG_STEP    = 3'd3,
    CFG_START_X = 3'd4,
    CFG_START_Y = 3'd5,
    CFG_START_Z = 3'd6
  } cfg_reg_t;

  // Microcode fields
  typedef enum logic [1:0] {
    OP_NOP,
    OP_ADD,
    OP_SUB,
    OP_MUL
  } op_t;

  typedef enum logic [3:0] {
    SRC_X,
    SRC_Y,
    SRC_Z,
    SRC_T0,
    SRC_T1,
    SRC_T2,
    SRC_T3,
    SRC_SG,
    SRC_RH,
    SRC_BT,
    SRC_DT
  } src_t;

  typedef enum logic [2:0] {
    DST_X,
    DST_Y,
    DST_Z,
    DST_T0,
    DST_T1,
    DST_T2,
    DST_T3
  } dst_t;

  typedef enum logic [1:0] {
    JMP_NEXT,       // advance when the step completes
    JMP_WAIT_IN,    // hold until a transaction arrives on the input
    JMP_EMIT_HOME   // hold until the output slot frees, emit, jump to target
  } jmp_t;

  localparam int unsigned PROG_LEN = 15;
  localparam int unsigned PC_BITS  = $clog2(PROG_LEN);

  typedef logic [PC_BITS-1:0] pc_t;

  localparam pc_t PC_HOME  = PC_BITS'(0);
  localparam pc_t PC_FIRST = PC_BITS'(1);

  typedef struct packed {
    op_t  op;
    src_t a;
    src_t b;
    dst_t dst;
    jmp_t jmp;
    pc_t  target;
  } ctrl_word_t;

  // One Euler step: derivatives from the old point, then scale and add
  localparam ctrl_word_t PROGRAM [PROG_LEN] = '{
    '{OP_NOP, SRC_X,  SRC_X,  DST_X,  JMP_WAIT_IN,   PC_HOME},  // wait for tick
    '{OP_SUB, SRC_Y,  SRC_X,  DST_T0, JMP_NEXT,      PC_HOME},  // y - x
    '{OP_MUL, SRC_SG, SRC_T0, DST_T0, JMP_NEXT,      PC_HOME},  // dx
    '{OP_SUB, SRC_RH, SRC_Z,  DST_T1, JMP_NEXT,      PC_HOME},  // rho - z
    '{OP_MUL, SRC_X,  SRC_T1, DST_T1, JMP_NEXT,      PC_HOME},  // x (rho - z)
    '{OP_SUB, SRC_T1, SRC_Y,  DST_T1, JMP_NEXT,      PC_HOME},  // dy
    '{OP_MUL, SRC_X,  SRC_Y,  DST_T2, JMP_NEXT,      PC_HOME},  // x y
    '{OP_MUL, SRC_BT, SRC_Z,  DST_T3, JMP_NEXT,      PC_HOME},  // beta z
    '{OP_SUB, SRC_T2, SRC_T3, DST_T2, JMP_NEXT,      PC_HOME},  // dz
    '{OP_MUL, SRC_T0, SRC_DT, DST_T0, JMP_NEXT,      PC_HOME},  // dx dt
    '{OP_MUL, SRC_T1, SRC_DT, DST_T1, JMP_NEXT,      PC_HOME},  // dy dt
    '{OP_MUL, SRC_T2, SRC_DT, DST_T2, JMP_NEXT,      PC_HOME},  // dz dt
    '{OP_ADD, SRC_X,  SRC_T0, DST_X,  JMP_NEXT,      PC_HOME},  // new x
    '{OP_ADD, SRC_Y,  SRC_T1, DST_Y,  JMP_NEXT,      PC_HOME},  // new y
    '{OP_ADD, SRC_Z,  SRC_T2, DST_Z,  JMP_EMIT_HOME, PC_HOME}   // new z, emit
  };

  // Multiplier sequencing
  typedef enum logic [1:0] {
    MUL_IDLE,
    MUL_MAC,
    MUL_FIN
  } mul_state_t;

  typedef struct packed {
    logic idle;
    logic done;
    logic ovf;
  } mul_stat_t;

endpackage

`default_nettype wire

FILE: design/lorenz_if.sv
// ----------------------------------------------------------------------------
// lorenz_if
// Valid/ready channels of the Lorenz step unit: tick input and point output.
// ----------------------------------------------------------------------------
`default_nettype none

interface lorenz_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface lorenz_out_if;
  import lorenz_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [OUT_BITS-1:0] pos_x;
  logic signed [OUT_BITS-1:0] pos_y;
  logic signed [OUT_BITS-1:0] pos_z;
  logic                       overflow;

  modport source (output valid, output pos_x, output pos_y, output pos_z,
                  output overflow, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                  input overflow, output ready);
endinterface

`default_nettype wire

FILE: design/lorenz_mul.sv
// ----------------------------------------------------------------------------
// lorenz_mul
// Shared fixed-point multiplier: sign-magnitude chunked multiply-accumulate,
// then floor shift by the fraction bits and saturation to the word range.
// ----------------------------------------------------------------------------
`default_nettype none

module lorenz_mul #(
  parameter int unsigned WORD_BITS = lorenz_pkg::WORD_BITS_DEF,
  parameter int unsigned FRAC_BITS = lorenz_pkg::FRAC_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [WORD_BITS-1:0]  a,
  input  wire logic [WORD_BITS-1:0]  b,
  output logic      [WORD_BITS-1:0]  res,
  output lorenz_pkg::mul_stat_t      stat
);
  import lorenz_pkg::*;

  localparam int unsigned NC  = (WORD_BITS + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int unsigned MW  = NC * MUL_CHUNK;
  localparam int unsigned PW  = 2 * MW;
  localparam int unsigned IW  = (NC > 1) ? $clog2(NC) : 1;
  localparam int unsigned SHW = $clog2(PW);

  localparam logic [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  mul_state_t state, state_next;

  logic [MW-1:0]          ma, mb;
  logic                   neg;
  logic [PW-1:0]          acc;
  logic [IW-1:0]          ia, ib;
  logic                   done;
  logic                   ovf;

  logic [MUL_CHUNK-1:0]   a_chunk, b_chunk;
  logic [2*MUL_CHUNK-1:0] pp;
  logic [SHW-1:0]         sh;
  logic [PW-1:0]          pp_sh;
  logic                   mac_last;
  logic [PW-1:0]          prod_s;
  logic [PW-1:0]          shifted;
  logic [PW-WORD_BITS:0]  hi;
  logic                   fits;
  logic [WORD_BITS-1:0]   fin_val;

  // Partial product of the current chunk pair
  always_comb begin
    a_chunk  = ma[ia*MUL_CHUNK +: MUL_CHUNK];
    b_chunk  = mb[ib*MUL_CHUNK +: MUL_CHUNK];
    pp       = a_chunk * b_chunk;
    sh       = SHW'(MUL_CHUNK * (int'(ia) + int'(ib)));
    pp_sh    = PW'(pp) << sh;
    mac_last = (ia == IW'(NC - 1)) && (ib == IW'(NC - 1));
  end

  // Restore sign, floor shift, saturate
  always_comb begin
    prod_s  = neg ? (~acc + PW'(1)) : acc;
    shifted = PW'($signed(prod_s) >>> FRAC_BITS);
    hi      = shifted[PW-1:WORD_BITS-1];
    fits    = (&hi) | ~(|hi);
    fin_val = fits ? shifted[WORD_BITS-1:0] : (shifted[PW-1] ? WMIN : WMAX);
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MUL_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      MUL_IDLE: if (start) state_next = MUL_MAC;
      MUL_MAC:  if (mac_last) state_next = MUL_FIN;
      MUL_FIN:  state_next = MUL_IDLE;
      default:  state_next = MUL_IDLE;
    endcase
  end

  // Completion pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == MUL_FIN);
    end
  end

  // Operand capture, accumulate, finish
  always_ff @(posedge clk) begin
    case (state)
      MUL_IDLE: begin
        if (start) begin
          neg <= a[WORD_BITS-1] ^ b[WORD_BITS-1];
          ma  <= MW'(a[WORD_BITS-1] ? (~a + WORD_BITS'(1)) : a);
          mb  <= MW'(b[WORD_BITS-1] ? (~b + WORD_BITS'(1)) : b);
          acc <= '0;
          ia  <= '0;
          ib  <= '0;
        end
      end
      MUL_MAC: begin
        acc <= acc + pp_sh;
        if (ib == IW'(NC - 1)) begin
          ib <= '0;
          ia <= ia + IW'(1);
        end else begin
          ib <= ib + IW'(1);
        end
      end
      MUL_FIN: begin
        res <= fin_val;
        ovf <= ~fits;
      end
      default: ;
    endcase
  end

  assign stat.idle = (state == MUL_IDLE);
  assign stat.done = done;
  assign stat.ovf  = ovf;

  // Checks
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> (state == MUL_IDLE))
    else $error("multiplier started while busy");

  a_done_after_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(done) |-> $past(state == MUL_FIN))
    else $error("multiplier done without finish cycle");

  a_fin_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (state == MUL_FIN) |=> (state == MUL_IDLE))
    else $error("multiplier finish not followed by idle");

endmodule

`default_nettype wire

FILE: design/lorenz_euler_step_unit.sv
// ----------------------------------------------------------------------------
// lorenz_euler_step_unit
// Lorenz attractor generator: one forward-Euler step per input tick.
// ----------------------------------------------------------------------------
// Each accepted tick advances the stored point (x,y,z) by one Euler step of
// the Lorenz system in signed fixed point (WORD_BITS wide, FRAC_BITS fraction
// bits; Q8.24 by default), products rounded toward negative infinity and every
// intermediate saturated to the word range, and emits the new point with an
// overflow flag. A tick with restart set first reloads the point from the
// start registers. A 15-step microprogram drives one adder and one shared
// multiplier; a multiply accumulates one partial product per pair of 32-bit
// operand chunks, NC = ceil(WORD_BITS/32) per operand, then shifts and
// saturates, and an add or subtract is combinational. The time from an
// accepted tick to its result is set chiefly by the seven passes through
// the multiplier. The program returns home in the same cycle that the result
// is loaded into the output register; the next tick is taken as soon as it
// is home, while the previous result may still sit in the output register,
// and a result that cannot leave holds the final step. Configuration must
// be written by the user only while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module lorenz_euler_step_unit #(
  parameter int unsigned WORD_BITS = lorenz_pkg::WORD_BITS_DEF,
  parameter int unsigned FRAC_BITS = lorenz_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  lorenz_in_if.sink                                 in_ch,
  lorenz_out_if.source                              out_ch,
  input  wire logic                                 cfg_we,
  input  wire logic [lorenz_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [lorenz_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import lorenz_pkg::*;

  localparam int unsigned CW = ((WORD_BITS > START_BITS) ? WORD_BITS : START_BITS) + 1;
  localparam logic [CW-1:0] WMAX_C = (CW'(1) << (WORD_BITS - 1)) - CW'(1);
  localparam logic [CW-1:0] WMIN_C = ~WMAX_C;
  localparam logic [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  // Clamp a register value into the word range; top bit flags saturation
  function automatic logic [WORD_BITS:0] sat_word(input logic [CW-1:0] v);
    logic [WORD_BITS:0] r;
    if ($signed(v) > $signed(WMAX_C)) begin
      r = {1'b1, WMAX};
    end else if ($signed(v) < $signed(WMIN_C)) begin
      r = {1'b1, WMIN};
    end else begin
      r = {1'b0, v[WORD_BITS-1:0]};
    end
    return r;
  endfunction

  // Configuration registers
  logic [COEF_BITS-1:0]  sigma, rho, beta;
  logic [STEP_BITS-1:0]  step_size;
  logic [START_BITS-1:0] start_x, start_y, start_z;

  // Working registers
  logic [WORD_BITS-1:0] x, y, z, t0, t1, t2, t3;
  logic [WORD_BITS-1:0] x_next, y_next, z_next;
  logic                 ovf, ovf_next;
  pc_t                  pc, pc_next;

  // Output register
  logic                       out_valid;
  logic signed [OUT_BITS-1:0] out_x, out_y, out_z;
  logic                       out_ovf;

  // Clamped operands
  logic [WORD_BITS:0] sg_c, rh_c, bt_c, dt_c, sx_c, sy_c, sz_c;
  logic               cfg_ovf, start_ovf;

  ctrl_word_t           cw;
  logic [WORD_BITS-1:0] opa, opb;
  logic [WORD_BITS:0]   sum;
  logic                 alu_flag;
  logic [WORD_BITS-1:0] alu_val;
  logic [WORD_BITS-1:0] wr_val;
  logic                 wr_flag;
  logic                 step_done;
  logic                 slot_free;
  logic                 in_fire;
  logic                 emit;
  logic                 wr_en;

  logic                 mul_start;
  logic [WORD_BITS-1:0] mul_res;
  mul_stat_t            mul_stat;

  // Configuration writes; out-of-range indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      sigma     <= SIGMA_RST;
      rho       <= RHO_RST;
      beta      <= BETA_RST;
      step_size <= STEP_RST;
      start_x   <= START_X_RST;
      start_y   <= START_Y_RST;
      start_z   <= START_Z_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_SIGMA:   sigma     <= cfg_data[COEF_BITS-1:0];
        CFG_RHO:     rho       <= cfg_data[COEF_BITS-1:0];
        CFG_BETA:    beta      <= cfg_data[COEF_BITS-1:0];
        CFG_STEP:    step_size <= cfg_data[STEP_BITS-1:0];
        CFG_START_X: start_x   <= cfg_data[START_BITS-1:0];
        CFG_START_Y: start_y   <= cfg_data[START_BITS-1:0];
        CFG_START_Z: start_z   <= cfg_data[START_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Clamp coefficients and start values into the word range
  always_comb begin
    sg_c      = sat_word(CW'(sigma));
    rh_c      = sat_word(CW'(rho));
    bt_c      = sat_word(CW'(beta));
    dt_c      = sat_word(CW'(step_size));
    sx_c      = sat_word(CW'($signed(start_x)));
    sy_c      = sat_word(CW'($signed(start_y)));
    sz_c      = sat_word(CW'($signed(start_z)));
    cfg_ovf   = sg_c[WORD_BITS] | rh_c[WORD_BITS] | bt_c[WORD_BITS] | dt_c[WORD_BITS];
    start_ovf = sx_c[WORD_BITS] | sy_c[WORD_BITS] | sz_c[WORD_BITS];
  end

  // Fetch the control word and select operands
  always_comb begin
    cw = PROGRAM[pc];
    case (cw.a)
      SRC_X:   opa = x;
      SRC_Y:   opa = y;
      SRC_Z:   opa = z;
      SRC_T0:  opa = t0;
      SRC_T1:  opa = t1;
      SRC_T2:  opa = t2;
      SRC_T3:  opa = t3;
      SRC_SG:  opa = sg_c[WORD_BITS-1:0];
      SRC_RH:  opa = rh_c[WORD_BITS-1:0];
      SRC_BT:  opa = bt_c[WORD_BITS-1:0];
      SRC_DT:  opa = dt_c[WORD_BITS-1:0];
      default: opa = '0;
    endcase
    case (cw.b)
      SRC_X:   opb = x;
      SRC_Y:   opb = y;
      SRC_Z:   opb = z;
      SRC_T0:  opb = t0;
      SRC_T1:  opb = t1;
      SRC_T2:  opb = t2;
      SRC_T3:  opb = t3;
      SRC_SG:  opb = sg_c[WORD_BITS-1:0];
      SRC_RH:  opb = rh_c[WORD_BITS-1:0];
      SRC_BT:  opb = bt_c[WORD_BITS-1:0];
      SRC_DT:  opb = dt_c[WORD_BITS-1:0];
      default: opb = '0;
    endcase
  end

  // Saturating add/subtract
  always_comb begin
    if (cw.op == OP_SUB) begin
      sum = {opa[WORD_BITS-1], opa} - {opb[WORD_BITS-1], opb};
    end else begin
      sum = {opa[WORD_BITS-1], opa} + {opb[WORD_BITS-1], opb};
    end
    alu_flag = sum[WORD_BITS] ^ sum[WORD_BITS-1];
    alu_val  = alu_flag ? (sum[WORD_BITS] ? WMIN : WMAX) : sum[WORD_BITS-1:0];
  end

  // Shared multiplier
  assign mul_start = (cw.op == OP_MUL) && mul_stat.idle && !mul_stat.done;

  lorenz_mul #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (opa),
    .b     (opb),
    .res   (mul_res),
    .stat  (mul_stat)
  );

  // Sequencer: step completion, jumps, register writes
  always_comb begin
    in_fire   = in_ch.valid && (cw.jmp == JMP_WAIT_IN);
    slot_free = !out_valid || out_ch.ready;
    case (cw.op)
      OP_MUL:  step_done = mul_stat.done;
      default: step_done = 1'b1;
    endcase
    wr_val  = (cw.op == OP_MUL) ? mul_res : alu_val;
    wr_flag = (cw.op == OP_MUL) ? mul_stat.ovf : alu_flag;
    emit    = (cw.jmp == JMP_EMIT_HOME) && step_done && slot_free;
    wr_en   = (cw.op != OP_NOP) && step_done &&
              ((cw.jmp != JMP_EMIT_HOME) || slot_free);

    pc_next = pc;
    case (cw.jmp)
      JMP_WAIT_IN:   if (in_fire) pc_next = pc + PC_BITS'(1);
      JMP_NEXT:      if (step_done) pc_next = pc + PC_BITS'(1);
      JMP_EMIT_HOME: if (emit) pc_next = cw.target;
      default:       pc_next = PC_HOME;
    endcase

    x_next   = x;
    y_next   = y;
    z_next   = z;
    ovf_next = ovf;
    if (in_fire) begin
      ovf_next = cfg_ovf | (in_ch.restart & start_ovf);
      if (in_ch.restart) begin
        x_next = sx_c[WORD_BITS-1:0];
        y_next = sy_c[WORD_BITS-1:0];
        z_next = sz_c[WORD_BITS-1:0];
      end
    end else if (wr_en) begin
      ovf_next = ovf | wr_flag;
      case (cw.dst)
        DST_X:   x_next = wr_val;
        DST_Y:   y_next = wr_val;
        DST_Z:   z_next = wr_val;
        default: ;
      endcase
    end
  end

  // Control state and point
  always_ff @(posedge clk) begin
    if (rst) begin
      pc  <= PC_HOME;
      ovf <= 1'b0;
      x   <= WORD_BITS'(START_X_RST);
      y   <= WORD_BITS'(START_Y_RST);
      z   <= WORD_BITS'(START_Z_RST);
    end else begin
      pc  <= pc_next;
      ovf <= ovf_next;
      x   <= x_next;
      y   <= y_next;
      z   <= z_next;
    end
  end

  // Temporaries
  always_ff @(posedge clk) begin
    if (wr_en) begin
      case (cw.dst)
        DST_T0:  t0 <= wr_val;
        DST_T1:  t1 <= wr_val;
        DST_T2:  t2 <= wr_val;
        DST_T3:  t3 <= wr_val;
        default: ;
      endcase
    end
  end

  // Output register: load on emit, drop when the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_x   <= OUT_BITS'($signed(x_next));
      out_y   <= OUT_BITS'($signed(y_next));
      out_z   <= OUT_BITS'($signed(z_next));
      out_ovf <= ovf_next;
    end
  end

  assign in_ch.ready     = (cw.jmp == JMP_WAIT_IN);
  assign out_ch.valid    = out_valid;
  assign out_ch.pos_x    = out_x;
  assign out_ch.pos_y    = out_y;
  assign out_ch.pos_z    = out_z;
  assign out_ch.overflow = out_ovf;

  // Checks
  a_home_mul_quiet: assert property (@(posedge clk) disable iff (rst)
    (cw.jmp == JMP_WAIT_IN) |-> (mul_stat.idle && !mul_stat.done))
    else $error("multiplier active while sequencer is home");

  a_done_in_mul_step: assert property (@(posedge clk) disable iff (rst)
    mul_stat.done |-> (cw.op == OP_MUL))
    else $error("multiplier result outside a multiply step");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> (pc == PC_FIRST))
    else $error("accepted tick did not start the program");

  a_emit_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cw.jmp == JMP_EMIT_HOME))
    else $error("result raised outside the emit step");

endmodule

`default_nettype wire

FILE: tb/sv/lorenz_point_checker.sv
// ----------------------------------------------------------------------------
// lorenz_point_checker
// Watches the tick and point channels and the register write port of the
// Lorenz step unit, computes each new point with its own fixed-point Euler
// step, and compares every emitted point field by field in arrival order.
// ----------------------------------------------------------------------------
module lorenz_point_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  lorenz_in_if                                 in_ch,
  lorenz_out_if                                out_ch,
  input  logic                                 cfg_we,
  input  logic [lorenz_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [lorenz_pkg::CFG_DATA_BITS-1:0] cfg_data,
  output int                                   failures,
  output int                                   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import lorenz_pkg::*;

  localparam longint WORD_MAX = (longint'(1) <<< (WORD_BITS_DEF - 1)) - 1;
  localparam longint WORD_MIN = -WORD_MAX - 1;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] pos_x;
    logic signed [OUT_BITS-1:0] pos_y;
    logic signed [OUT_BITS-1:0] pos_z;
    logic                       overflow;
  } point_t;

  // Shadow copy of the register file and the stored point
  logic [COEF_BITS-1:0]         sigma, rho, beta;
  logic [STEP_BITS-1:0]         step_size;
  logic signed [START_BITS-1:0] start_x, start_y, start_z;
  longint                       cur_x, cur_y, cur_z;

  bit     saturated;
  point_t predicted_points[$];
  int     mismatches;

  // Clamp to the word range and flag the step when it bites
  function automatic longint clamp_word(longint v);
    if (v > WORD_MAX) begin
      saturated = 1'b1;
      return WORD_MAX;
    end
    if (v < WORD_MIN) begin
      saturated = 1'b1;
      return WORD_MIN;
    end
    return v;
  endfunction

  function automatic longint fx_add(longint a, longint b);
    return clamp_word(a + b);
  endfunction

  function automatic longint fx_sub(longint a, longint b);
    return clamp_word(a - b);
  endfunction

  // Full product, then floor by the fraction bits (arithmetic shift)
  function automatic longint fx_mul(longint a, longint b);
    return clamp_word((a * b) >>> FRAC_BITS_DEF);
  endfunction

  // Advance the stored point by one Euler step and return the emitted point
  function automatic point_t euler_step(logic restart);
    longint x, y, z, dx, dy, dz, sg, rh, bt, dt;
    point_t p;
    saturated = 1'b0;
    if (restart) begin
      cur_x = clamp_word(longint'(start_x));
      cur_y = clamp_word(longint'(start_y));
      cur_z = clamp_word(longint'(start_z));
    end
    sg = clamp_word(longint'(sigma));
    rh = clamp_word(longint'(rho));
    bt = clamp_word(longint'(beta));
    dt = clamp_word(longint'(step_size));
    x = cur_x;
    y = cur_y;
    z = cur_z;
    dx = fx_mul(sg, fx_sub(y, x));
    dy = fx_sub(fx_mul(x, fx_sub(rh, z)), y);
    dz = fx_sub(fx_mul(x, y), fx_mul(bt, z));
    cur_x = fx_add(x, fx_mul(dx, dt));
    cur_y = fx_add(y, fx_mul(dy, dt));
    cur_z = fx_add(z, fx_mul(dz, dt));
    p.pos_x    = cur_x[OUT_BITS-1:0];
    p.pos_y    = cur_y[OUT_BITS-1:0];
    p.pos_z    = cur_z[OUT_BITS-1:0];
    p.overflow = saturated;
    return p;
  endfunction

  // Mirror a register write; unused indexes are dropped
  function automatic void apply_write(logic [CFG_IDX_BITS-1:0] idx,
                                      logic [CFG_DATA_BITS-1:0] data);
    case (idx)
      CFG_SIGMA:   sigma     = data[COEF_BITS-1:0];
      CFG_RHO:     rho       = data[COEF_BITS-1:0];
      CFG_BETA:    beta      = data[COEF_BITS-1:0];
      CFG_STEP:    step_size = data[STEP_BITS-1:0];
      CFG_START_X: start_x   = data[START_BITS-1:0];
      CFG_START_Y: start_y   = data[START_BITS-1:0];
      CFG_START_Z: start_z   = data[START_BITS-1:0];
      default: ;
    endcase
  endfunction

  task automatic check_field(string field, longint want, longint got);
    if (want != got) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  // Track writes and ticks, compare each emitted point
  always @(posedge clk) begin : watch
    point_t want;
    point_t fresh;
    if (rst) begin
      sigma     = SIGMA_RST;
      rho       = RHO_RST;
      beta      = BETA_RST;
      step_size = STEP_RST;
      start_x   = START_X_RST;
      start_y   = START_Y_RST;
      start_z   = START_Z_RST;
      cur_x     = longint'(signed'(START_X_RST));
      cur_y     = longint'(signed'(START_Y_RST));
      cur_z     = longint'(signed'(START_Z_RST));
      predicted_points.delete();
    end else begin
      if (cfg_we) begin
        apply_write(cfg_index, cfg_data);
      end
      if (in_ch.valid && in_ch.ready) begin
        fresh = euler_step(in_ch.restart);
        predicted_points = {predicted_points, fresh};
      end
      if (out_ch.valid && out_ch.ready) begin
        if (predicted_points.size() == 0) begin
          mismatches++;
          $display("%0t ns: point emitted with none expected, actual x=%0d y=%0d z=%0d ovf=%0d",
                   $time, out_ch.pos_x, out_ch.pos_y, out_ch.pos_z, out_ch.overflow);
        end else begin
          want = predicted_points.pop_front();
          check_field("pos_x", want.pos_x, out_ch.pos_x);
          check_field("pos_y", want.pos_y, out_ch.pos_y);
          check_field("pos_z", want.pos_z, out_ch.pos_z);
          check_field("overflow", want.overflow, out_ch.overflow);
        end
      end
    end
    failures    <= mismatches;
    outstanding <= predicted_points.size();
  end

endmodule

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives ticks and register writes into the Lorenz step unit under random
// flow control on both channels: a directed pass over register extremes,
// restart and saturation corners, then randomized phases with realistic,
// noisy and corner configurations. The checker judges every point.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lorenz_pkg::*;

  // Index with no register behind it
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 3'd7;

  localparam int unsigned Q_ONE = 1 << FRAC_BITS_DEF;

  typedef enum int {
    MODE_LORENZ,
    MODE_NOISE,
    MODE_CORNER
  } cfg_mode_t;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;
  int                       fails;
  int                       pending;
  bit                       calm_in;
  bit                       calm_out;

  lorenz_in_if  in_ch ();
  lorenz_out_if out_ch ();

  lorenz_euler_step_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lorenz_point_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .failures    (fails),
    .outstanding (pending)
  );

  always #2 clk = ~clk;

  // Hard stop well past the slowest legal run
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Drop and raise ready at random, with quiet stretches
  initial begin
    int unsigned gap;
    forever begin
      if ($urandom_range(0, 39) == 0) calm_out = !calm_out;
      gap = calm_out ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // One register write; the enable is lowered by the next tick
  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // Present one tick and hold it until the transaction completes
  task automatic send_tick(logic restart);
    int unsigned gap;
    if ($urandom_range(0, 29) == 0) calm_in = !calm_in;
    gap = calm_in ? 0 : $urandom_range(0, 6);
    cfg_we <= 1'b0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.restart <= restart;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Stop ticking and wait until every predicted point has come out
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic load_config(logic [31:0] sg, logic [31:0] rh, logic [31:0] bt,
                             logic [31:0] dt, logic [31:0] sx, logic [31:0] sy,
                             logic [31:0] sz);
    settle();
    write_reg(CFG_SIGMA, sg);
    write_reg(CFG_RHO, rh);
    write_reg(CFG_BETA, bt);
    write_reg(CFG_STEP, dt);
    write_reg(CFG_START_X, sx);
    write_reg(CFG_START_Y, sy);
    write_reg(CFG_START_Z, sz);
  endtask

  // Draw a register value: near a base, fully random, or a corner code
  function automatic logic [31:0] pick_word(cfg_mode_t mode, logic [31:0] base,
                                            int unsigned span);
    case (mode)
      MODE_LORENZ: return base + $urandom_range(0, 2 * span) - span;
      MODE_NOISE:  return $urandom();
      default: begin
        case ($urandom_range(0, 3))
          0:       return 32'h0000_0000;
          1:       return 32'hFFFF_FFFF;
          2:       return 32'h7FFF_FFFF;
          default: return 32'h8000_0000;
        endcase
      end
    endcase
  endfunction

  initial begin
    cfg_mode_t mode;
    int unsigned pick;
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_SIGMA;
    cfg_data      <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.restart <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Run from the reset point, then restart from the reset start values
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);

    // All-ones writes: top bits dropped, start values at the word bounds
    load_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    write_reg(CFG_SPARE, 32'h0000_0000);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);

    // Zero coefficients and zero step: the point must hold
    load_config(32'h0, 32'h0, 32'h0, 32'h0, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0);
    write_reg(CFG_SPARE, 32'hFFFF_FFFF);
    send_tick(1'b1);
    send_tick(1'b0);

    // Unit step with unit coefficients from a small negative point
    load_config(Q_ONE, Q_ONE, Q_ONE, Q_ONE, -(Q_ONE / 2), -Q_ONE, -(Q_ONE * 3));
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);

    // Reset coefficients, odd start values
    load_config(32'(SIGMA_RST), 32'(RHO_RST), 32'(BETA_RST), 32'(STEP_RST),
                32'hFFFF_FFFF, 32'h1, 32'h8000_0000);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);

    // Random phases, each a fresh configuration and a restart
    for (int ph = 0; ph < 26; ph++) begin
      pick = $urandom_range(0, 9);
      mode = (pick < 6) ? MODE_LORENZ : (pick < 8) ? MODE_NOISE : MODE_CORNER;
      load_config(pick_word(mode, 10 * Q_ONE, 4 * Q_ONE),
                  pick_word(mode, 28 * Q_ONE, 8 * Q_ONE),
                  pick_word(mode, SIGMA_RST / 60, Q_ONE),
                  pick_word(mode, Q_ONE / 32, Q_ONE / 32),
                  pick_word(mode, 0, 20 * Q_ONE),
                  pick_word(mode, 0, 20 * Q_ONE),
                  pick_word(mode, 20 * Q_ONE, 20 * Q_ONE));
      if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE, $urandom());
      send_tick(1'b1);
      repeat (24) send_tick($urandom_range(0, 7) == 0);
    end

    // Drain, then give any stray point time to show up
    settle();
    repeat (60) @(posedge clk);
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/lorenz_pkg.sv
design/lorenz_if.sv
design/lorenz_mul.sv
design/lorenz_euler_step_unit.sv
tb/sv/lorenz_point_checker.sv
tb/sv/testbench.sv
